// ===== design/mexp_pkg.sv =====
// mexp_pkg: widths and helpers shared by the modular exponentiation block
// no dependencies
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int FIELD_W      = 31;
    localparam int OPERAND_BITS = 31;
    localparam int CNT_W        = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;

    typedef logic [OPERAND_BITS-1:0] t_opnd;
    typedef logic [FIELD_W-1:0]      t_field;
    typedef logic [CNT_W-1:0]        t_cnt;

    localparam t_cnt LAST_BIT = CNT_W'(OPERAND_BITS - 1);

    function automatic t_opnd narrow(input t_field x);
        t_opnd y;
        y = x[OPERAND_BITS-1:0];
        return y;
    endfunction

    function automatic t_field widen(input t_opnd x);
        t_field y;
        y = '0;
        y[OPERAND_BITS-1:0] = x;
        return y;
    endfunction

endpackage

// ===== design/mexp_mulmod.sv =====
// mexp_mulmod: shared modular multiplier, interleaved shift-add with reduction
// one multiplier bit per cycle; uses mexp_pkg
`timescale 1ns / 1ps

module mexp_mulmod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mexp_pkg::t_opnd i_a,
    input  mexp_pkg::t_opnd i_b,
    input  mexp_pkg::t_opnd i_n,
    output logic            o_done,
    output mexp_pkg::t_opnd o_result
);

    localparam int W = mexp_pkg::OPERAND_BITS;

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    mexp_pkg::t_cnt  r_cnt, n_cnt;
    mexp_pkg::t_opnd r_acc, n_acc;
    mexp_pkg::t_opnd r_a, n_a;
    mexp_pkg::t_opnd r_b, n_b;

    logic [W:0]      dbl, d1, sum, d2, nz;
    mexp_pkg::t_opnd addend;

    always_comb begin
        nz     = {1'b0, i_n};
        dbl    = {r_acc, 1'b0};
        d1     = (dbl >= nz) ? dbl - nz : dbl;
        addend = r_a[W-1] ? r_b : '0;
        sum    = d1 + {1'b0, addend};
        d2     = (sum >= nz) ? sum - nz : sum;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
        end else if (r_busy) begin
            n_acc = d2[W-1:0];
            n_a   = {r_a[W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == mexp_pkg::LAST_BIT) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

// ===== design/modular_exponentiation.sv =====
// modular_exponentiation: top level, square-and-multiply sequencer around mexp_mulmod
// uses mexp_pkg and mexp_mulmod
`timescale 1ns / 1ps

// Computes base_value ^ exponent mod modulus. One item at a time: o_in_stall is
// high from acceptance until the result is written to the output register. The
// base is first reduced (one modular multiply), then each of the 31 exponent
// bits costs a squaring plus a multiply when the bit is set. Every modular
// multiply runs on the single shared shift-add unit at one bit per cycle. The
// modulus register resets to 1 and ignores writes of zero; write it only
// while no item is in flight.
module modular_exponentiation (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mexp_pkg::t_field     i_base_value,
    input  mexp_pkg::t_field     i_exponent,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mexp_pkg::t_field     o_power_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  mexp_pkg::t_field     i_cfg_modulus
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQR  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]       r_state, n_state;
    mexp_pkg::t_opnd  r_modulus, n_modulus;
    mexp_pkg::t_opnd  r_acc, n_acc;
    mexp_pkg::t_opnd  r_sq, n_sq;
    mexp_pkg::t_opnd  r_exp, n_exp;
    mexp_pkg::t_cnt   r_bit, n_bit;
    logic             r_mul_start, n_mul_start;
    mexp_pkg::t_opnd  r_mul_a, n_mul_a;
    mexp_pkg::t_opnd  r_mul_b, n_mul_b;
    logic             r_out_valid, n_out_valid;
    mexp_pkg::t_field r_out_data, n_out_data;

    logic             mul_done;
    mexp_pkg::t_opnd  mul_res;
    mexp_pkg::t_opnd  one_mod;
    mexp_pkg::t_opnd  cfg_v;
    logic             in_acc;
    logic             next_bit_set;

    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_a      (r_mul_a),
        .i_b      (r_mul_b),
        .i_n      (r_modulus),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    assign one_mod      = (r_modulus == mexp_pkg::t_opnd'(1)) ? '0 : mexp_pkg::t_opnd'(1);
    assign cfg_v        = mexp_pkg::narrow(i_cfg_modulus);
    assign in_acc       = i_in_valid && !o_in_stall;
    assign next_bit_set = r_exp[r_bit + 1'b1];

    always_comb begin
        n_state     = r_state;
        n_modulus   = r_modulus;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_exp       = r_exp;
        n_bit       = r_bit;
        n_mul_start = 1'b0;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_valid && cfg_v != '0) begin
            n_modulus = cfg_v;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_acc       = one_mod;
                    n_exp       = mexp_pkg::narrow(i_exponent);
                    n_bit       = '0;
                    n_mul_a     = mexp_pkg::narrow(i_base_value);
                    n_mul_b     = one_mod;
                    n_mul_start = 1'b1;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                if (mul_done) begin
                    n_sq        = mul_res;
                    n_mul_start = 1'b1;
                    if (r_exp[r_bit]) begin
                        n_mul_a = r_acc;
                        n_mul_b = mul_res;
                        n_state = S_MUL;
                    end else begin
                        n_mul_a = mul_res;
                        n_mul_b = mul_res;
                        n_state = S_SQR;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_acc       = mul_res;
                    n_mul_a     = r_sq;
                    n_mul_b     = r_sq;
                    n_mul_start = 1'b1;
                    n_state     = S_SQR;
                end
            end
            S_SQR: begin
                if (mul_done) begin
                    n_sq = mul_res;
                    if (r_bit == mexp_pkg::LAST_BIT) begin
                        n_state = S_FIN;
                    end else begin
                        n_bit       = r_bit + 1'b1;
                        n_mul_start = 1'b1;
                        if (next_bit_set) begin
                            n_mul_a = r_acc;
                            n_mul_b = mul_res;
                            n_state = S_MUL;
                        end else begin
                            n_mul_a = mul_res;
                            n_mul_b = mul_res;
                            n_state = S_SQR;
                        end
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = mexp_pkg::widen(r_acc);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= mexp_pkg::t_opnd'(1);
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_bit       <= '0;
        end else begin
            r_state     <= n_state;
            r_modulus   <= n_modulus;
            r_mul_start <= n_mul_start;
            r_out_valid <= n_out_valid;
            r_bit       <= n_bit;
        end
        r_acc      <= n_acc;
        r_sq       <= n_sq;
        r_exp      <= n_exp;
        r_mul_a    <= n_mul_a;
        r_mul_b    <= n_mul_b;
        r_out_data <= n_out_data;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_out_data;
    assign o_cfg_ready    = 1'b1;

endmodule

// ===== design/mexp_checker.sv =====
// mexp_port_checks: port-level assertions for modular_exponentiation, bound to the top
// uses mexp_pkg; follows modular_exponentiation
`timescale 1ns / 1ps

module mexp_port_checks (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input mexp_pkg::t_field o_power_result
);

    // an accepted item keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after item accepted");

    // a result never appears right after acceptance
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared in the cycle after acceptance");

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_power_result)))
        else $error("stalled result changed");

endmodule

bind modular_exponentiation mexp_port_checks u_mexp_port_checks (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_power_result (o_power_result)
);
